### hw/rtl/lfu_pkg.sv
package lfu_pkg;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_UPDATE
	} lfu_state_t;

	typedef struct packed {
		logic start;
		logic step;
		logic commit;
	} lfu_cmd_t;

	typedef struct packed {
		logic last;
		logic out_busy;
	} lfu_sts_t;

	localparam logic KIND_GET = 1'b0;
	localparam logic KIND_PUT = 1'b1;

	localparam int CAP_BITS = 5;
	localparam logic [CAP_BITS-1:0] CAP_RESET = 5'd16;

endpackage

### hw/rtl/lfu_req_if.sv
interface lfu_req_if;
	logic valid;
	logic ready;
	logic kind;
	logic signed [31:0] key;
	logic signed [31:0] value;

	modport source (output valid, kind, key, value, input ready);
	modport sink (input valid, kind, key, value, output ready);
endinterface

### hw/rtl/lfu_rsp_if.sv
interface lfu_rsp_if;
	logic valid;
	logic ready;
	logic hit;
	logic signed [31:0] read_value;
	logic evicted;
	logic signed [31:0] evicted_key;

	modport source (output valid, hit, read_value, evicted, evicted_key, input ready);
	modport sink (input valid, hit, read_value, evicted, evicted_key, output ready);
endinterface

### hw/rtl/lfu_ctrl.sv
module lfu_ctrl
	import lfu_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     req_valid,
	output logic     req_ready,
	input  lfu_sts_t sts,
	output lfu_cmd_t cmd
);

	lfu_state_t state_q, state_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_n;
		end
	end

	always_comb begin
		state_n = state_q;
		cmd = '0;
		req_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					cmd.start = 1'b1;
					state_n = ST_SCAN;
				end
			end
			ST_SCAN: begin
				cmd.step = 1'b1;
				if (sts.last) state_n = ST_UPDATE;
			end
			ST_UPDATE: begin
				if (!sts.out_busy) begin
					cmd.commit = 1'b1;
					state_n = ST_IDLE;
				end
			end
			default: state_n = ST_IDLE;
		endcase
	end

endmodule

### hw/rtl/lfu_datapath.sv
module lfu_datapath
	import lfu_pkg::*;
#(
	parameter int MAX_ENTRIES = 16,
	parameter int COUNT_BITS = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  lfu_cmd_t            cmd,
	output lfu_sts_t            sts,
	input  logic                cfg_we,
	input  logic [CAP_BITS-1:0] cfg_wdata,
	input  logic                in_kind,
	input  logic signed [31:0]  in_key,
	input  logic signed [31:0]  in_value,
	output logic                out_valid,
	input  logic                out_ready,
	output logic                out_hit,
	output logic signed [31:0]  out_read_value,
	output logic                out_evicted,
	output logic signed [31:0]  out_evicted_key
);

	localparam int IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int CW = $clog2(MAX_ENTRIES + 1);
	localparam int UW = (CW > CAP_BITS) ? CW : CAP_BITS;
	localparam logic [IW-1:0] LAST_IDX = IW'(MAX_ENTRIES - 1);
	localparam logic [UW-1:0] MAX_CAP = UW'(MAX_ENTRIES);

	logic [MAX_ENTRIES-1:0] valid_q;
	logic [31:0]            key_q   [MAX_ENTRIES];
	logic [31:0]            value_q [MAX_ENTRIES];
	logic [COUNT_BITS-1:0]  count_q [MAX_ENTRIES];
	logic [IW-1:0]          rank_q  [MAX_ENTRIES];

	logic [CAP_BITS-1:0]   cap_q;
	logic                  kind_q;
	logic [31:0]           rkey_q, rval_q;
	logic [IW-1:0]         idx_q, match_q, free_q, vic_q;
	logic                  match_found_q, free_found_q, vic_found_q;
	logic [CW-1:0]         used_q;
	logic [COUNT_BITS-1:0] vic_cnt_q;
	logic [IW-1:0]         vic_rank_q;

	logic                  rsp_valid_q, rsp_hit_q, rsp_evicted_q;
	logic [31:0]           rsp_rdata_q, rsp_evkey_q;

	logic                  better;
	logic [UW-1:0]         cap_eff, used_ext;
	logic                  cap_zero, do_evict;

	assign sts.last = (idx_q == LAST_IDX);
	assign sts.out_busy = rsp_valid_q && !out_ready;

	assign better = !vic_found_q || (count_q[idx_q] < vic_cnt_q) ||
		(count_q[idx_q] == vic_cnt_q && rank_q[idx_q] > vic_rank_q);

	assign cap_zero = (cap_q == '0);
	assign cap_eff = (UW'(cap_q) > MAX_CAP) ? MAX_CAP : UW'(cap_q);
	assign used_ext = UW'(used_q);
	assign do_evict = (used_ext >= cap_eff) || !free_found_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAP_RESET;
		end else if (cfg_we) begin
			cap_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			kind_q <= in_kind;
			rkey_q <= in_key;
			rval_q <= in_value;
			idx_q <= '0;
			match_found_q <= 1'b0;
			free_found_q <= 1'b0;
			vic_found_q <= 1'b0;
			used_q <= '0;
			match_q <= '0;
			free_q <= '0;
			vic_q <= '0;
			vic_cnt_q <= '0;
			vic_rank_q <= '0;
		end else if (cmd.step) begin
			idx_q <= idx_q + 1'b1;
			if (valid_q[idx_q]) begin
				used_q <= used_q + 1'b1;
				if (key_q[idx_q] == rkey_q) begin
					match_found_q <= 1'b1;
					match_q <= idx_q;
				end
				if (better) begin
					vic_found_q <= 1'b1;
					vic_q <= idx_q;
					vic_cnt_q <= count_q[idx_q];
					vic_rank_q <= rank_q[idx_q];
				end
			end else if (!free_found_q) begin
				free_found_q <= 1'b1;
				free_q <= idx_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (rsp_valid_q && out_ready) rsp_valid_q <= 1'b0;
			if (cmd.commit) begin
				rsp_valid_q <= 1'b1;
				if (!cap_zero && !match_found_q && kind_q == KIND_PUT &&
					!(do_evict && vic_found_q) && free_found_q) begin
					valid_q[free_q] <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			rsp_hit_q <= 1'b0;
			rsp_rdata_q <= '0;
			rsp_evicted_q <= 1'b0;
			rsp_evkey_q <= '0;
			if (!cap_zero) begin
				if (match_found_q) begin
					rsp_hit_q <= 1'b1;
					if (kind_q == KIND_GET) rsp_rdata_q <= value_q[match_q];
					else value_q[match_q] <= rval_q;
					if (count_q[match_q] != '1) count_q[match_q] <= count_q[match_q] + 1'b1;
					for (int i = 0; i < MAX_ENTRIES; i++) begin
						if (IW'(i) != match_q && valid_q[i] && rank_q[i] < rank_q[match_q])
							rank_q[i] <= rank_q[i] + 1'b1;
					end
					rank_q[match_q] <= '0;
				end else if (kind_q == KIND_PUT) begin
					if (do_evict && vic_found_q) begin
						rsp_evicted_q <= 1'b1;
						rsp_evkey_q <= key_q[vic_q];
						key_q[vic_q] <= rkey_q;
						value_q[vic_q] <= rval_q;
						count_q[vic_q] <= COUNT_BITS'(1);
						for (int i = 0; i < MAX_ENTRIES; i++) begin
							if (IW'(i) != vic_q && valid_q[i] && rank_q[i] < rank_q[vic_q])
								rank_q[i] <= rank_q[i] + 1'b1;
						end
						rank_q[vic_q] <= '0;
					end else if (free_found_q) begin
						key_q[free_q] <= rkey_q;
						value_q[free_q] <= rval_q;
						count_q[free_q] <= COUNT_BITS'(1);
						for (int i = 0; i < MAX_ENTRIES; i++) begin
							if (IW'(i) != free_q && valid_q[i])
								rank_q[i] <= rank_q[i] + 1'b1;
						end
						rank_q[free_q] <= '0;
					end
				end
			end
		end
	end

	assign out_valid = rsp_valid_q;
	assign out_hit = rsp_hit_q;
	assign out_read_value = rsp_rdata_q;
	assign out_evicted = rsp_evicted_q;
	assign out_evicted_key = rsp_evkey_q;

`ifndef SYNTHESIS
	a_commit_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |=> rsp_valid_q)
		else $error("response not raised after commit");
	a_hit_no_evict: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q |-> !(rsp_hit_q && rsp_evicted_q))
		else $error("hit and eviction together");
	a_fill_grows: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(valid_q) >= $past($countones(valid_q)))
		else $error("valid entry lost");
	a_commit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |-> (!rsp_valid_q || out_ready))
		else $error("commit over pending response");
`endif

endmodule

### hw/rtl/lfu_cache_table.sv
// Channel | Dir | Fields
// req     | in  | kind, key, value
// rsp     | out | hit, read_value, evicted, evicted_key
// cfg     | in  | cfg_we, cfg_wdata (capacity_in_use)
//
// One word is accepted, then scanned slot by slot for key match, fill count,
// free slot and victim, then committed in the update state.
// Reset clears valid bits and the response register; capacity resets to 16.
// A held response stalls the update cycle; the next request waits for it.
module lfu_cache_table
	import lfu_pkg::*;
#(
	parameter int MAX_ENTRIES = 16,
	parameter int COUNT_BITS = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	lfu_req_if.sink             req,
	lfu_rsp_if.source           rsp,
	input  logic                cfg_we,
	input  logic [CAP_BITS-1:0] cfg_wdata
);

	lfu_cmd_t cmd;
	lfu_sts_t sts;

	lfu_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	lfu_datapath #(
		.MAX_ENTRIES (MAX_ENTRIES),
		.COUNT_BITS  (COUNT_BITS)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.sts             (sts),
		.cfg_we          (cfg_we),
		.cfg_wdata       (cfg_wdata),
		.in_kind         (req.kind),
		.in_key          (req.key),
		.in_value        (req.value),
		.out_valid       (rsp.valid),
		.out_ready       (rsp.ready),
		.out_hit         (rsp.hit),
		.out_read_value  (rsp.read_value),
		.out_evicted     (rsp.evicted),
		.out_evicted_key (rsp.evicted_key)
	);

endmodule
